/* src/tls_pkg.sv */
package tls_pkg;

   localparam int LineLength = 64;
   localparam int IdxW = $clog2(LineLength);
   localparam int CntW = $clog2(LineLength + 1);
   localparam int DataW = 32;
   localparam int DivCycles = 48;
   localparam int DivCntW = $clog2(DivCycles + 1);

   localparam logic signed [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
   localparam logic signed [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

   typedef struct packed {
      logic load;
      logic mul_num;
      logic mul_den;
      logic sub;
      logic div_start;
      logic store;
      logic bs_load;
      logic bs_read;
      logic bs_mul;
      logic bs_sub;
      logic out_load;
      logic line_clear;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic row_full;
      logic last_row;
      logic bs_empty;
      logic out_busy;
   } stat_type;

   function automatic logic signed [DataW-1:0] sat64(input logic signed [63:0] v);
      logic signed [DataW-1:0] r;
      if (v > 64'sh7FFF_FFFF) r = SatMax;
      else if (v < -64'sh8000_0000) r = SatMin;
      else r = v[DataW-1:0];
      return r;
   endfunction

   function automatic logic signed [DataW-1:0] qscale(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> 16;
      return sat64(s);
   endfunction

endpackage

/* src/tls_ram.sv */
module tls_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

/* src/tls_div.sv */
module tls_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [tls_pkg::DataW-1:0] num,
   input  logic signed [tls_pkg::DataW-1:0] den,
   output logic                             done,
   output logic signed [tls_pkg::DataW-1:0] quo
);
   localparam int NW = tls_pkg::DivCycles;

   logic [NW-1:0] rem_ff, rem_in;
   logic [NW-1:0] q_ff, q_in;
   logic [NW-1:0] n_ff, n_in;
   logic [31:0] d_ff, d_in;
   logic neg_ff, neg_in;
   logic [tls_pkg::DivCntW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [NW:0] trial;
   logic signed [63:0] sq;

   assign trial = {rem_ff, n_ff[NW-1]} - {{(NW-31){1'b0}}, d_ff};

   always_comb begin
      rem_in = rem_ff;
      q_in = q_ff;
      n_in = n_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         n_in = {(num[31] ? 32'(-num) : 32'(num)), 16'h0};
         d_in = den[31] ? 32'(-den) : 32'(den);
         neg_in = num[31] ^ den[31];
         rem_in = '0;
         q_in = '0;
         cnt_in = tls_pkg::DivCntW'(tls_pkg::DivCycles);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[NW]) begin
            rem_in = trial[NW-1:0];
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[NW-2:0], n_ff[NW-1]};
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         n_in = {n_ff[NW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == tls_pkg::DivCntW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff <= q_in;
      n_ff <= n_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
   end

   assign sq = neg_ff ? -$signed({16'h0, q_ff}) : $signed({16'h0, q_ff});
   assign quo = tls_pkg::sat64(sq);
   assign done = busy_ff && (cnt_ff == tls_pkg::DivCntW'(1));
endmodule

/* src/tls_datapath.sv */
module tls_datapath (
   input  logic                             clock,
   input  tls_pkg::cmd_type                 cmd,
   output tls_pkg::stat_type                stat,
   input  logic signed [tls_pkg::DataW-1:0] req_a_coef,
   input  logic signed [tls_pkg::DataW-1:0] req_b_coef,
   input  logic signed [tls_pkg::DataW-1:0] req_c_coef,
   input  logic signed [tls_pkg::DataW-1:0] req_f_value,
   input  logic signed [tls_pkg::DataW-1:0] req_carry_c,
   input  logic signed [tls_pkg::DataW-1:0] req_carry_d,
   input  logic signed [tls_pkg::DataW-1:0] req_upper_x,
   input  logic                             req_first_row,
   input  logic                             req_last_row,
   input  logic                             reset,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [tls_pkg::IdxW-1:0]         rsp_row_index,
   output logic signed [tls_pkg::DataW-1:0] rsp_x_value,
   output logic                             rsp_pivot_zero,
   output logic                             rsp_last
);
   localparam int DW = tls_pkg::DataW;

   logic signed [DW-1:0] a_ff, b_ff, c_ff, f_ff, ux_ff;
   logic signed [DW-1:0] rc_ff, rd_ff;
   logic signed [DW-1:0] num_ff, den_ff, cp_ff;
   logic signed [63:0] prod_ff;
   logic last_ff;
   logic [tls_pkg::CntW-1:0] cnt_ff, cnt_in;
   logic flag_ff, flag_in;
   logic [tls_pkg::CntW-1:0] bi_ff;
   logic signed [DW-1:0] x_ff;
   logic signed [DW-1:0] c_rd, d_rd, quo, div_num;
   logic div_done;
   logic phase_ff;
   logic signed [DW-1:0] wr_c, wr_d;
   logic ov_ff;
   logic [tls_pkg::IdxW-1:0] ov_idx_ff;
   logic signed [DW-1:0] ov_x_ff;
   logic ov_flag_ff, ov_last_ff;
   logic [tls_pkg::IdxW-1:0] rd_addr;

   assign div_num = phase_ff ? num_ff : c_ff;
   assign wr_c = (den_ff == '0) ? '0 : cp_ff;
   assign wr_d = (den_ff == '0) ? '0 : quo;
   assign rd_addr = tls_pkg::IdxW'(bi_ff - 1'b1);

   tls_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .num(div_num), .den(den_ff), .done(div_done), .quo(quo)
   );

   tls_ram #(.Width(DW), .Depth(tls_pkg::LineLength)) u_cram (
      .clock(clock), .wr_en(cmd.store), .wr_addr(tls_pkg::IdxW'(cnt_ff)),
      .wr_data(wr_c), .rd_addr(rd_addr), .rd_data(c_rd)
   );
   tls_ram #(.Width(DW), .Depth(tls_pkg::LineLength)) u_dram (
      .clock(clock), .wr_en(cmd.store), .wr_addr(tls_pkg::IdxW'(cnt_ff)),
      .wr_data(wr_d), .rd_addr(rd_addr), .rd_data(d_rd)
   );

   always_comb begin
      cnt_in = cnt_ff;
      flag_in = flag_ff;
      if (cmd.load && req_first_row) begin
         cnt_in = '0;
         flag_in = 1'b0;
      end
      if (cmd.store) begin
         cnt_in = cnt_ff + 1'b1;
         if (den_ff == '0) flag_in = 1'b1;
      end
      if (cmd.line_clear) begin
         cnt_in = '0;
         flag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         flag_ff <= 1'b0;
         rc_ff <= '0;
         rd_ff <= '0;
         phase_ff <= 1'b0;
         ov_ff <= 1'b0;
         bi_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         flag_ff <= flag_in;
         if (cmd.load && req_first_row) begin
            rc_ff <= req_carry_c;
            rd_ff <= req_carry_d;
         end
         if (cmd.store) begin
            rc_ff <= wr_c;
            rd_ff <= wr_d;
         end
         if (cmd.line_clear) begin
            rc_ff <= '0;
            rd_ff <= '0;
         end
         if (cmd.load) phase_ff <= 1'b0;
         if (cmd.mul_num) phase_ff <= 1'b1;
         if (cmd.bs_load) bi_ff <= cnt_in;
         if (cmd.bs_read) bi_ff <= bi_ff - 1'b1;
         if (cmd.out_load) ov_ff <= 1'b1;
         else if (!rsp_stall) ov_ff <= 1'b0;
      end
      if (cmd.load) begin
         a_ff <= req_a_coef;
         b_ff <= req_b_coef;
         c_ff <= req_c_coef;
         f_ff <= req_f_value;
         ux_ff <= req_upper_x;
         last_ff <= req_last_row;
      end
      if (cmd.mul_den) prod_ff <= 64'(a_ff) * 64'(rc_ff);
      if (cmd.mul_num) prod_ff <= 64'(a_ff) * 64'(rd_ff);
      if (cmd.sub) begin
         if (!phase_ff)
            den_ff <= tls_pkg::sat64(64'(b_ff) - 64'(tls_pkg::qscale(prod_ff)));
         else
            num_ff <= tls_pkg::sat64(64'(f_ff) - 64'(tls_pkg::qscale(prod_ff)));
      end
      if (cmd.mul_num) cp_ff <= quo;
      if (cmd.bs_load) x_ff <= ux_ff;
      if (cmd.bs_mul) prod_ff <= 64'(c_rd) * 64'(x_ff);
      if (cmd.bs_sub) x_ff <= tls_pkg::sat64(64'(d_rd) - 64'(tls_pkg::qscale(prod_ff)));
      if (cmd.out_load) begin
         ov_idx_ff <= rd_addr;
         ov_x_ff <= tls_pkg::sat64(64'(d_rd) - 64'(tls_pkg::qscale(prod_ff)));
         ov_flag_ff <= flag_ff;
         ov_last_ff <= bi_ff == tls_pkg::CntW'(1);
      end
   end

   assign stat.div_done = div_done;
   assign stat.row_full = cnt_ff == tls_pkg::CntW'(tls_pkg::LineLength);
   assign stat.last_row = last_ff;
   assign stat.bs_empty = bi_ff == '0;
   assign stat.out_busy = ov_ff && rsp_stall;

   assign rsp_valid = ov_ff;
   assign rsp_row_index = ov_idx_ff;
   assign rsp_x_value = ov_x_ff;
   assign rsp_pivot_zero = ov_flag_ff;
   assign rsp_last = ov_last_ff;
endmodule

/* src/tls_ctrl.sv */
module tls_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_first_row,
   output tls_pkg::cmd_type  cmd,
   input  tls_pkg::stat_type stat
);
   localparam logic [3:0] Idle = 4'd0, Mden = 4'd1, Sden = 4'd2, DivC = 4'd3,
      DivCw = 4'd4, Mnum = 4'd5, Snum = 4'd6, DivD = 4'd7, DivDw = 4'd8,
      Store = 4'd9, BsStart = 4'd10, BsRead = 4'd11, BsMul = 4'd12, BsOut = 4'd13,
      Done = 4'd14;

   localparam int WaitW = tls_pkg::DivCntW;

   logic [3:0] st_ff, st_in;
   logic [WaitW-1:0] w_ff, w_in;
   logic full_eff;

   assign full_eff = stat.row_full && !(req_first_row);

   always_comb begin
      st_in = st_ff;
      w_in = w_ff;
      cmd = '0;
      req_stall = 1'b1;
      unique case (st_ff)
         Idle: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               st_in = full_eff ? BsStart : Mden;
            end
         end
         Mden: begin cmd.mul_den = 1'b1; st_in = Sden; end
         Sden: begin cmd.sub = 1'b1; st_in = DivC; end
         DivC: begin
            cmd.div_start = 1'b1;
            st_in = DivCw;
         end
         DivCw: begin
            if (stat.div_done) st_in = Mnum;
         end
         Mnum: begin cmd.mul_num = 1'b1; st_in = Snum; end
         Snum: begin cmd.sub = 1'b1; st_in = DivD; end
         DivD: begin
            cmd.div_start = 1'b1;
            st_in = DivDw;
         end
         DivDw: begin
            if (stat.div_done) st_in = Store;
         end
         Store: begin cmd.store = 1'b1; st_in = BsStart; end
         BsStart: begin
            if (!stat.last_row) st_in = Idle;
            else begin
               cmd.bs_load = 1'b1;
               st_in = BsRead;
            end
         end
         BsRead: begin
            if (stat.bs_empty) begin
               cmd.line_clear = 1'b1;
               st_in = Idle;
            end else begin
               st_in = BsMul;
            end
         end
         BsMul: begin
            w_in = '0;
            if (w_ff == '0) w_in = WaitW'(1);
            else begin cmd.bs_mul = 1'b1; w_in = '0; st_in = BsOut; end
         end
         BsOut: begin
            if (!stat.out_busy) begin
               cmd.bs_sub = 1'b1;
               cmd.out_load = 1'b1;
               cmd.bs_read = 1'b1;
               st_in = BsRead;
            end
         end
         default: st_in = Idle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= Idle;
         w_ff <= '0;
      end else begin
         st_ff <= st_in;
         w_ff <= w_in;
      end
   end

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != Idle |-> req_stall) else $error("accepts while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !stat.out_busy) else $error("result overwritten");
   a_store_once: assert property (@(posedge clock) disable iff (reset)
      cmd.store |=> !cmd.store) else $error("double store");
endmodule

/* src/tridiagonal_line_solver.sv */
// channel | valid     | stall     | payload
// req     | req_valid | req_stall | a/b/c/f, carry_c/d, upper_x, first_row, last_row
// rsp     | rsp_valid | rsp_stall | row_index, x_value, pivot_zero, last
// A stored row beat stalls the input while one divider computes two 48-step quotients in turn.
// A row past the line length is not stored; unless it is a last row, it stalls the input only in BsStart.
// A last row then emits one beat per pass through BsRead, BsMul and BsOut, row count-1 down to 0,
// and clears the line in a final BsRead. Synchronous active-high reset clears the sweep; row stores are not cleared.
// A stalled beat holds the back substitution until it is taken.
module tridiagonal_line_solver (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [tls_pkg::DataW-1:0] req_a_coef,
   input  logic signed [tls_pkg::DataW-1:0] req_b_coef,
   input  logic signed [tls_pkg::DataW-1:0] req_c_coef,
   input  logic signed [tls_pkg::DataW-1:0] req_f_value,
   input  logic signed [tls_pkg::DataW-1:0] req_carry_c,
   input  logic signed [tls_pkg::DataW-1:0] req_carry_d,
   input  logic signed [tls_pkg::DataW-1:0] req_upper_x,
   input  logic                             req_first_row,
   input  logic                             req_last_row,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tls_pkg::IdxW-1:0]         rsp_row_index,
   output logic signed [tls_pkg::DataW-1:0] rsp_x_value,
   output logic                             rsp_pivot_zero,
   output logic                             rsp_last
);
   tls_pkg::cmd_type cmd;
   tls_pkg::stat_type stat;

   tls_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_first_row(req_first_row), .cmd(cmd), .stat(stat)
   );

   tls_datapath u_dp (
      .clock(clock), .cmd(cmd), .stat(stat),
      .req_a_coef(req_a_coef), .req_b_coef(req_b_coef), .req_c_coef(req_c_coef),
      .req_f_value(req_f_value), .req_carry_c(req_carry_c),
      .req_carry_d(req_carry_d), .req_upper_x(req_upper_x),
      .req_first_row(req_first_row), .req_last_row(req_last_row),
      .reset(reset), .rsp_stall(rsp_stall), .rsp_valid(rsp_valid),
      .rsp_row_index(rsp_row_index), .rsp_x_value(rsp_x_value),
      .rsp_pivot_zero(rsp_pivot_zero), .rsp_last(rsp_last)
   );
endmodule
